FILE: design/tkdp_pkg.sv
// shared types and constants for the top-k dot-product search block
package tkdp_pkg;

   localparam int VocabDepth = 1024;
   localparam int VectorDim  = 128;
   localparam int TopK       = 16;
   localparam int MaxIgnore  = 4;

   // input item opcodes
   localparam logic [1:0] OP_WR_TABLE = 2'd0;
   localparam logic [1:0] OP_WR_QUERY = 2'd1;
   localparam logic [1:0] OP_IGNORE   = 2'd2;
   localparam logic [1:0] OP_SEARCH   = 2'd3;

   // register indexes
   localparam logic [1:0] REG_VOCAB = 2'd0;
   localparam logic [1:0] REG_DIMS  = 2'd1;
   localparam logic [1:0] REG_TOPK  = 2'd2;
   localparam logic [1:0] REG_FLOOR = 2'd3;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [9:0]         row;
      logic [6:0]         col;
      logic signed [15:0] value;
   } req_type;

   typedef struct packed {
      logic [3:0]         rank;
      logic [9:0]         word_index;
      logic signed [31:0] score;
      logic               slot_valid;
      logic               last;
   } rsp_type;

   // control travelling along the chain of list cells
   typedef struct packed {
      logic clear;  // empty every cell
      logic ins;    // offer a candidate
      logic shift;  // move contents one cell towards rank 0 (readout)
   } cell_ctl_type;

endpackage

FILE: design/tkdp_cell.sv
// one slot of the sorted best list; compares the candidate and hands its entry down
module tkdp_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  tkdp_pkg::cell_ctl_type ctl,
   input  logic                 en,        // this slot is within top_k_used
   input  logic signed [31:0]   cand_score,
   input  logic [9:0]           cand_row,
   input  logic                 up_valid,  // neighbour towards rank 0 holds an entry
   input  logic                 up_beats,  // candidate beats the upper neighbour
   input  logic signed [31:0]   up_score,
   input  logic [9:0]           up_row,
   input  logic                 dn_valid,  // neighbour away from rank 0
   input  logic signed [31:0]   dn_score,
   input  logic [9:0]           dn_row,
   output logic                 beats,
   output logic                 valid,
   output logic signed [31:0]   score,
   output logic [9:0]           row
);

   logic               valid_ff, valid_in;
   logic signed [31:0] score_ff, score_in;
   logic [9:0]         row_ff, row_in;
   logic               upper_taken;

   // candidate wins this slot if slot empty or strictly better
   assign beats = !valid_ff || (cand_score > score_ff);
   // upper slot counts as taken-by-candidate when valid and candidate beat it
   assign upper_taken = up_valid && up_beats;

   always_comb begin
      valid_in = valid_ff;
      score_in = score_ff;
      row_in   = row_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.shift) begin
         valid_in = dn_valid;
         score_in = dn_score;
         row_in   = dn_row;
      end else if (ctl.ins && en && beats) begin
         if (upper_taken) begin
            // candidate sits above: take the upper entry
            valid_in = 1'b1;
            score_in = up_score;
            row_in   = up_row;
         end else if (up_valid) begin
            // upper slot keeps its entry: candidate lands here
            valid_in = 1'b1;
            score_in = cand_score;
            row_in   = cand_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      score_ff <= score_in;
      row_ff   <= row_in;
   end

   assign valid = valid_ff;
   assign score = score_ff;
   assign row   = row_ff;

endmodule

FILE: design/tkdp_list.sv
// chain of list cells holding the best rows in descending score order
module tkdp_list #(
   parameter int TOP_K = tkdp_pkg::TopK
) (
   input  logic                   clock,
   input  logic                   reset,
   input  tkdp_pkg::cell_ctl_type ctl,
   input  logic [6:0]             k_used,
   input  logic signed [31:0]     cand_score,
   input  logic [9:0]             cand_row,
   output logic                   head_valid,
   output logic signed [31:0]     head_score,
   output logic [9:0]             head_row
);

   logic               beats [TOP_K];
   logic               vld   [TOP_K];
   logic signed [31:0] scr   [TOP_K];
   logic [9:0]         rw    [TOP_K];

   for (genvar i = 0; i < TOP_K; i++) begin : g_cell
      logic               u_v, u_b, d_v;
      logic signed [31:0] u_s, d_s;
      logic [9:0]         u_r, d_r;
      if (i == 0) begin : g_first
         // rank 0 has no upper neighbour: acts as a filled slot never beaten
         assign u_v = 1'b1;
         assign u_b = 1'b0;
         assign u_s = '0;
         assign u_r = '0;
      end else begin : g_mid
         assign u_v = vld[i-1];
         assign u_b = beats[i-1];
         assign u_s = scr[i-1];
         assign u_r = rw[i-1];
      end
      if (i == TOP_K - 1) begin : g_end
         assign d_v = 1'b0;
         assign d_s = '0;
         assign d_r = '0;
      end else begin : g_inner
         assign d_v = vld[i+1];
         assign d_s = scr[i+1];
         assign d_r = rw[i+1];
      end
      tkdp_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .en         (7'(i) < k_used),
         .cand_score (cand_score),
         .cand_row   (cand_row),
         .up_valid   (u_v),
         .up_beats   (u_b),
         .up_score   (u_s),
         .up_row     (u_r),
         .dn_valid   (d_v),
         .dn_score   (d_s),
         .dn_row     (d_r),
         .beats      (beats[i]),
         .valid      (vld[i]),
         .score      (scr[i]),
         .row        (rw[i])
      );
   end

   assign head_valid = vld[0];
   assign head_score = scr[0];
   assign head_row   = rw[0];

endmodule

FILE: design/top_k_dot_product_search.sv
// top level: vector and query stores, multiply-accumulate sequencer and best list
// pacing: a search runs one multiply-accumulate per cycle through the single read port
//   of the vector store; an ignored row is skipped without any multiply-accumulate
// throughput: one item at a time; results leave one per cycle when taken
// reset: synchronous, active high; clears control, registers to defaults,
//   ignore list and best list; the stores stay undefined until written
module top_k_dot_product_search #(
   parameter int VOCAB_DEPTH = tkdp_pkg::VocabDepth,
   parameter int VECTOR_DIM  = tkdp_pkg::VectorDim,
   parameter int TOP_K       = tkdp_pkg::TopK,
   parameter int MAX_IGNORE  = tkdp_pkg::MaxIgnore
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tkdp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tkdp_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata
);

   localparam int RW = (VOCAB_DEPTH > 1) ? $clog2(VOCAB_DEPTH) : 1;
   localparam int CW = (VECTOR_DIM > 1) ? $clog2(VECTOR_DIM) : 1;
   localparam int IW = $clog2(MAX_IGNORE + 1);
   localparam int IXW = (MAX_IGNORE > 1) ? $clog2(MAX_IGNORE) : 1;
   localparam int AW = RW + CW;

   // state codes
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CLEAR = 3'd1;
   localparam logic [2:0] ST_ROW   = 3'd2;
   localparam logic [2:0] ST_MAC   = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;
   localparam logic [2:0] ST_INS   = 3'd5;
   localparam logic [2:0] ST_OUT   = 3'd6;

   // configuration registers
   logic [10:0]        vocab_ff;
   logic [7:0]         dims_ff;
   logic [4:0]         topk_ff;
   logic signed [31:0] floor_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vocab_ff <= 11'd1024;
         dims_ff  <= 8'd128;
         topk_ff  <= 5'd16;
         floor_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            tkdp_pkg::REG_VOCAB: vocab_ff <= csr_wdata[10:0];
            tkdp_pkg::REG_DIMS:  dims_ff  <= csr_wdata[7:0];
            tkdp_pkg::REG_TOPK:  topk_ff  <= csr_wdata[4:0];
            tkdp_pkg::REG_FLOOR: floor_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // clamped limits
   logic [16:0] rows_lim;
   logic [10:0] dims_lim;
   logic [6:0]  k_lim;
   always_comb begin
      rows_lim = (17'(vocab_ff) > 17'(VOCAB_DEPTH)) ? 17'(VOCAB_DEPTH) : 17'(vocab_ff);
      dims_lim = (11'(dims_ff) > 11'(VECTOR_DIM)) ? 11'(VECTOR_DIM) : 11'(dims_ff);
      k_lim    = (7'(topk_ff) > 7'(TOP_K)) ? 7'(TOP_K) : 7'(topk_ff);
      if (k_lim == 7'd0) k_lim = 7'd1;
   end

   logic [2:0]         state_ff, state_in;
   logic [16:0]        r_ff, r_in;
   logic [10:0]        c_ff, c_in;
   logic [6:0]         o_ff, o_in;
   logic [IW-1:0]      icnt_ff, icnt_in;
   logic [9:0]         irow_ff [MAX_IGNORE];
   logic signed [47:0] acc_ff, acc_in;
   logic signed [31:0] prod_ff;
   logic               pv_ff, pv_in;    // product register holds a term
   logic               rv_ff, rv_in;    // read data valid
   logic signed [15:0] vrd_ff, qrd_ff;
   logic signed [31:0] cand_ff, cand_in;
   logic               rsp_valid_ff, rsp_valid_in;
   tkdp_pkg::rsp_type  rsp_ff, rsp_in;
   tkdp_pkg::cell_ctl_type ctl;
   logic               head_valid;
   logic signed [31:0] head_score;
   logic [9:0]         head_row;

   logic acc_req;
   assign acc_req = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // vector and query memories
   logic signed [15:0] vmem [VOCAB_DEPTH * VECTOR_DIM];
   logic signed [15:0] qmem [VECTOR_DIM];
   logic               mac_rd;
   assign mac_rd = (state_ff == ST_MAC);

   always_ff @(posedge clock) begin
      if (acc_req && req_data.opcode == tkdp_pkg::OP_WR_TABLE &&
          32'(req_data.row) < 32'(VOCAB_DEPTH) && 32'(req_data.col) < 32'(VECTOR_DIM)) begin
         vmem[AW'({req_data.row[RW-1:0], req_data.col[CW-1:0]})] <= req_data.value;
      end
      if (mac_rd) begin
         vrd_ff <= vmem[AW'({r_ff[RW-1:0], c_ff[CW-1:0]})];
      end
   end

   always_ff @(posedge clock) begin
      if (acc_req && req_data.opcode == tkdp_pkg::OP_WR_QUERY &&
          32'(req_data.col) < 32'(VECTOR_DIM)) begin
         qmem[req_data.col[CW-1:0]] <= req_data.value;
      end
      if (mac_rd) begin
         qrd_ff <= qmem[c_ff[CW-1:0]];
      end
   end

   // ignore list match for the current row
   logic ign_hit;
   always_comb begin
      ign_hit = 1'b0;
      for (int j = 0; j < MAX_IGNORE; j++) begin
         if (IW'(j) < icnt_ff && 17'(irow_ff[j]) == r_ff) ign_hit = 1'b1;
      end
   end

   // ignore list storage
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < MAX_IGNORE; j++) irow_ff[j] <= '0;
      end else if (acc_req && req_data.opcode == tkdp_pkg::OP_IGNORE &&
                   icnt_ff < IW'(MAX_IGNORE)) begin
         irow_ff[icnt_ff[IXW-1:0]] <= req_data.row;
      end
   end

   // saturate accumulator
   logic signed [31:0] sat;
   always_comb begin
      if (acc_ff > 48'sd2147483647)       sat = 32'sh7fffffff;
      else if (acc_ff < -48'sd2147483648) sat = 32'sh80000000;
      else                                sat = acc_ff[31:0];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      o_in         = o_ff;
      icnt_in      = icnt_ff;
      acc_in       = acc_ff;
      pv_in        = 1'b0;
      rv_in        = 1'b0;
      cand_in      = cand_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      ctl          = '0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (pv_ff) acc_in = acc_ff + 48'(prod_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (acc_req) begin
               if (req_data.opcode == tkdp_pkg::OP_IGNORE && icnt_ff < IW'(MAX_IGNORE))
                  icnt_in = icnt_ff + 1'b1;
               if (req_data.opcode == tkdp_pkg::OP_SEARCH) state_in = ST_CLEAR;
            end
         end
         ST_CLEAR: begin
            ctl.clear = 1'b1;
            r_in      = '0;
            state_in  = ST_ROW;
         end
         ST_ROW: begin
            c_in   = '0;
            acc_in = '0;
            if (r_ff >= rows_lim) begin
               o_in     = '0;
               state_in = ST_OUT;
            end else if (ign_hit) begin
               r_in = r_ff + 1'b1;
            end else if (dims_lim == 11'd0) begin
               state_in = ST_DRAIN;
            end else begin
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            rv_in = 1'b1;
            c_in  = c_ff + 1'b1;
            if (c_ff + 1'b1 >= dims_lim) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            // wait until read and product stages are empty
            if (!rv_ff && !pv_ff) begin
               cand_in  = sat;
               state_in = ST_INS;
            end
         end
         ST_INS: begin
            if (cand_ff > floor_ff) ctl.ins = 1'b1;
            r_in     = r_ff + 1'b1;
            state_in = ST_ROW;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_in.rank       = o_ff[3:0];
               rsp_in.slot_valid = head_valid;
               rsp_in.word_index = head_valid ? head_row : '0;
               rsp_in.score      = head_valid ? head_score : '0;
               rsp_in.last       = (o_ff + 1'b1 == k_lim);
               ctl.shift         = 1'b1;
               o_in              = o_ff + 1'b1;
               if (o_ff + 1'b1 == k_lim) begin
                  icnt_in  = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (rv_ff) pv_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         icnt_ff      <= '0;
         pv_ff        <= 1'b0;
         rv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         icnt_ff      <= icnt_in;
         pv_ff        <= pv_in;
         rv_ff        <= rv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      r_ff    <= r_in;
      c_ff    <= c_in;
      o_ff    <= o_in;
      acc_ff  <= acc_in;
      cand_ff <= cand_in;
      rsp_ff  <= rsp_in;
      prod_ff <= qrd_ff * vrd_ff;
   end

   // sorted best list
   tkdp_list #(.TOP_K(TOP_K)) u_list (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .k_used     (k_lim),
      .cand_score (cand_ff),
      .cand_row   (r_ff[9:0]),
      .head_valid (head_valid),
      .head_score (head_score),
      .head_row   (head_row)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: sim/top_k_dot_product_search_checker.sv
// scoreboard for the top-k dot-product search: mirrors the stores and predicts every ranked item
`timescale 1ns / 1ps

module top_k_dot_product_search_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  tkdp_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  tkdp_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [31:0]       csr_wdata,
   output int                failures,
   output int                pending
);

   // mirrored stores and list of rows to skip
   logic signed [15:0] table_mirror [0:tkdp_pkg::VocabDepth*tkdp_pkg::VectorDim-1];
   logic signed [15:0] query_mirror [0:tkdp_pkg::VectorDim-1];
   logic [9:0]         skip_rows [0:tkdp_pkg::MaxIgnore-1];
   int                 skip_count;

   // mirrored registers
   logic [10:0]        vocab_reg;
   logic [7:0]         dims_reg;
   logic [4:0]         topk_reg;
   logic signed [31:0] floor_reg;

   tkdp_pkg::rsp_type ranked_q [$];

   assign pending = ranked_q.size();

   // run one search on the mirror and queue the ranked items it reports
   task automatic rank_rows();
      int                 rows, dims, k, fill, pos, j;
      longint             acc;
      logic signed [31:0] s;
      logic signed [31:0] best_s [0:tkdp_pkg::TopK-1];
      logic [9:0]         best_r [0:tkdp_pkg::TopK-1];
      bit                 skipped;
      tkdp_pkg::rsp_type  item;
      rows = (vocab_reg > tkdp_pkg::VocabDepth) ? tkdp_pkg::VocabDepth : vocab_reg;
      dims = (dims_reg > tkdp_pkg::VectorDim) ? tkdp_pkg::VectorDim : dims_reg;
      k    = (topk_reg > tkdp_pkg::TopK) ? tkdp_pkg::TopK : topk_reg;
      if (k == 0) k = 1;
      fill = 0;
      for (int r = 0; r < rows; r++) begin
         skipped = 0;
         for (int i = 0; i < skip_count; i++)
            if (skip_rows[i] == r) skipped = 1;
         if (skipped) continue;
         acc = 0;
         for (int c = 0; c < dims; c++)
            acc += longint'(query_mirror[c]) *
                   longint'(table_mirror[r*tkdp_pkg::VectorDim + c]);
         if (acc > 64'sd2147483647) s = 32'sh7fffffff;
         else if (acc < -64'sd2147483648) s = 32'sh80000000;
         else s = acc[31:0];
         if (s <= floor_reg) continue;
         pos = 0;
         while (pos < fill && !(s > best_s[pos])) pos++;
         if (pos >= k) continue;
         if (fill < k) fill++;
         for (j = fill - 1; j > pos; j--) begin
            best_s[j] = best_s[j-1];
            best_r[j] = best_r[j-1];
         end
         best_s[pos] = s;
         best_r[pos] = r[9:0];
      end
      for (int i = 0; i < k; i++) begin
         item.rank       = i[3:0];
         item.slot_valid = (i < fill);
         item.word_index = (i < fill) ? best_r[i] : '0;
         item.score      = (i < fill) ? best_s[i] : '0;
         item.last       = (i == k - 1);
         ranked_q = {ranked_q, item};
      end
      skip_count = 0;
   endtask

   // watch all three ports
   always @(posedge clock) begin
      tkdp_pkg::rsp_type want;
      if (reset) begin
         vocab_reg  <= 11'd1024;
         dims_reg   <= 8'd128;
         topk_reg   <= 5'd16;
         floor_reg  <= '0;
         skip_count = 0;
         failures   = 0;
         ranked_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               tkdp_pkg::REG_VOCAB: vocab_reg <= csr_wdata[10:0];
               tkdp_pkg::REG_DIMS:  dims_reg  <= csr_wdata[7:0];
               tkdp_pkg::REG_TOPK:  topk_reg  <= csr_wdata[4:0];
               tkdp_pkg::REG_FLOOR: floor_reg <= csr_wdata;
            endcase
         end
         if (req_valid && req_ready) begin
            case (req_data.opcode)
               tkdp_pkg::OP_WR_TABLE:
                  table_mirror[req_data.row*tkdp_pkg::VectorDim + req_data.col] = req_data.value;
               tkdp_pkg::OP_WR_QUERY: query_mirror[req_data.col] = req_data.value;
               tkdp_pkg::OP_IGNORE: begin
                  if (skip_count < tkdp_pkg::MaxIgnore) begin
                     skip_rows[skip_count] = req_data.row;
                     skip_count++;
                  end
               end
               tkdp_pkg::OP_SEARCH: rank_rows();
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (ranked_q.size() == 0) begin
               $error("result item with nothing expected");
               failures++;
            end else begin
               want = ranked_q.pop_front();
               if (rsp_data.rank != want.rank) begin
                  $error("rank: expected %0d, got %0d", want.rank, rsp_data.rank);
                  failures++;
               end
               if (rsp_data.word_index != want.word_index) begin
                  $error("word_index: expected %0d, got %0d",
                         want.word_index, rsp_data.word_index);
                  failures++;
               end
               if (rsp_data.score != want.score) begin
                  $error("score: expected %0d, got %0d", want.score, rsp_data.score);
                  failures++;
               end
               if (rsp_data.slot_valid != want.slot_valid) begin
                  $error("slot_valid: expected %0d, got %0d",
                         want.slot_valid, rsp_data.slot_valid);
                  failures++;
               end
               if (rsp_data.last != want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_data.last);
                  failures++;
               end
            end
         end
      end
   end

endmodule

FILE: sim/top_k_dot_product_search_test.sv
// testbench top: drives items and register writes into the search block and gives the verdict
`timescale 1ns / 1ps

module top_k_dot_product_search_test;

   // components written for every row in use; searches keep dims within this
   localparam int FillDims = 4;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   tkdp_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   tkdp_pkg::rsp_type rsp_data;
   logic              csr_we;
   logic [1:0]        csr_index;
   logic [31:0]       csr_wdata;
   int                failures;
   int                pending;
   int                gap_max;
   int                cycles;
   logic signed [15:0] row2_vals [0:FillDims-1];

   top_k_dot_product_search u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   top_k_dot_product_search_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .failures(failures), .pending(pending)
   );

   // clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run guard
   initial cycles = 0;
   always @(posedge clock) begin
      cycles++;
      if (cycles > 1500000) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // result side: random stall before each item
   initial begin
      int n;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         n = (gap_max == 0) ? 0 : $urandom_range(0, 11);
         if (n > 0) begin
            rsp_ready = 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   // offer one item after a random gap and hold it until taken
   task automatic send_item(input logic [1:0] op, input logic [9:0] row,
                            input logic [6:0] col, input logic [15:0] val);
      int n;
      n = (gap_max == 0) ? 0 : $urandom_range(0, 11);
      if (n > 0) begin
         req_valid = 1'b0;
         repeat (n) @(negedge clock);
      end
      req_data.opcode = op;
      req_data.row    = row;
      req_data.col    = col;
      req_data.value  = val;
      req_valid       = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   // wait for every ranked item, then let the block settle
   task automatic wait_idle();
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we    = 1'b0;
   endtask

   task automatic search_with(input logic [1:0] idx, input logic [31:0] data);
      wait_idle();
      write_reg(idx, data);
      send_item(tkdp_pkg::OP_SEARCH, '0, '0, '0);
   endtask

   initial begin
      int          sel;
      logic [15:0] v;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = tkdp_pkg::REG_VOCAB;
      csr_wdata = '0;
      gap_max   = 11;
      reset     = 1'b1;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // fill query and rows 0..7 over the first components; row 3 copies row 2 for ties
      for (int c = 0; c < FillDims; c++) begin
         row2_vals[c] = 16'($urandom);
         send_item(tkdp_pkg::OP_WR_QUERY, '0, c[6:0], 16'h8000);
         send_item(tkdp_pkg::OP_WR_TABLE, 10'd0, c[6:0], 16'h8000);
         send_item(tkdp_pkg::OP_WR_TABLE, 10'd1, c[6:0], 16'h7fff);
         send_item(tkdp_pkg::OP_WR_TABLE, 10'd2, c[6:0], row2_vals[c]);
         send_item(tkdp_pkg::OP_WR_TABLE, 10'd3, c[6:0], row2_vals[c]);
         for (int r = 4; r < 8; r++)
            send_item(tkdp_pkg::OP_WR_TABLE, r[9:0], c[6:0], 16'($urandom));
      end

      // directed: saturation both ways, ties, ignore list, register extremes
      write_reg(tkdp_pkg::REG_VOCAB, 32'd8);
      write_reg(tkdp_pkg::REG_DIMS, 32'(FillDims));
      write_reg(tkdp_pkg::REG_TOPK, 32'd16);
      write_reg(tkdp_pkg::REG_FLOOR, 32'd0);
      send_item(tkdp_pkg::OP_SEARCH, '0, '0, '0);
      send_item(tkdp_pkg::OP_IGNORE, 10'd0, '0, '0);
      send_item(tkdp_pkg::OP_IGNORE, 10'd0, '0, '0);
      send_item(tkdp_pkg::OP_IGNORE, 10'd5, '0, '0);
      send_item(tkdp_pkg::OP_IGNORE, 10'd1023, '0, '0);
      send_item(tkdp_pkg::OP_IGNORE, 10'd2, '0, '0);
      send_item(tkdp_pkg::OP_SEARCH, '0, '0, '0);
      search_with(tkdp_pkg::REG_FLOOR, 32'h80000000);
      search_with(tkdp_pkg::REG_DIMS, 32'd0);
      search_with(tkdp_pkg::REG_TOPK, 32'd0);
      search_with(tkdp_pkg::REG_TOPK, 32'd31);
      search_with(tkdp_pkg::REG_DIMS, 32'(FillDims));
      search_with(tkdp_pkg::REG_FLOOR, 32'h7fffffff);
      search_with(tkdp_pkg::REG_VOCAB, 32'd0);
      wait_idle();
      write_reg(tkdp_pkg::REG_FLOOR, 32'h80000000);
      write_reg(tkdp_pkg::REG_TOPK, 32'd16);

      // random phases over small tables
      for (int ph = 0; ph < 4; ph++) begin
         wait_idle();
         write_reg(tkdp_pkg::REG_VOCAB,
                   ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom_range(1, 8));
         write_reg(tkdp_pkg::REG_DIMS, $urandom_range(0, FillDims));
         write_reg(tkdp_pkg::REG_TOPK, $urandom_range(0, 31));
         sel = $urandom_range(0, 3);
         write_reg(tkdp_pkg::REG_FLOOR, (sel == 0) ? 32'h80000000 :
                   (sel == 1) ? 32'h7fffffff : (sel == 2) ? 32'd0 : $urandom);
         for (int i = 0; i < 13; i++) begin
            sel = $urandom_range(0, 99);
            v = ($urandom_range(0, 4) == 0) ? (($urandom_range(0, 1) == 1) ? 16'h8000 : 16'h7fff)
                                            : 16'($urandom);
            if (i == 12 || sel < 35)
               send_item(tkdp_pkg::OP_SEARCH, 10'($urandom), 7'($urandom), 16'($urandom));
            else if (sel < 65)
               send_item(tkdp_pkg::OP_WR_TABLE, ($urandom_range(0, 3) == 0) ? 10'($urandom) :
                         10'($urandom_range(0, 7)), 7'($urandom), v);
            else if (sel < 85)
               send_item(tkdp_pkg::OP_WR_QUERY, 10'($urandom), 7'($urandom), v);
            else
               send_item(tkdp_pkg::OP_IGNORE, ($urandom_range(0, 3) == 0) ? 10'($urandom) :
                         10'($urandom_range(0, 7)), 7'($urandom), 16'($urandom));
         end
      end

      wait_idle();
      if (failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
design/tkdp_pkg.sv
design/tkdp_cell.sv
design/tkdp_list.sv
design/top_k_dot_product_search.sv
sim/top_k_dot_product_search_checker.sv
sim/top_k_dot_product_search_test.sv
